>>> hw/rtl/mebp_pkg.sv
// ----------------------------------------------------------------------------
// mebp_pkg
// Shared types, codes and helpers for the mesh element block packer.
// ----------------------------------------------------------------------------
package mebp_pkg;

  localparam int WORD_W = 32;
  localparam int ELEM_W = 3 * WORD_W;
  localparam int TYPE_W = 32;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_VERTEX  = 2'd0,
    CMD_TRI_ABS = 2'd1,
    CMD_TRI_REL = 2'd2,
    CMD_FLUSH   = 2'd3
  } cmd_t;

  // Result kind codes
  localparam logic KIND_DESC = 1'b0;
  localparam logic KIND_ELEM = 1'b1;

  // Packer control states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DESC,
    ST_ELEM
  } state_t;

  // Byte reverse of one word, applied when enabled
  function automatic logic [WORD_W-1:0] swap_word(input logic [WORD_W-1:0] x,
                                                  input logic en);
    logic [WORD_W-1:0] r;
    r = {x[7:0], x[15:8], x[23:16], x[31:24]};
    return en ? r : x;
  endfunction

endpackage

>>> hw/rtl/mebp_encode.sv
// ----------------------------------------------------------------------------
// mebp_encode
// Builds the stored 96-bit element from one input beat: raw vertex words or
// encoded triangle indices, byte-swapped when configured.
// ----------------------------------------------------------------------------
module mebp_encode
  import mebp_pkg::*;
(
  input  cmd_t              cmd,
  input  logic [WORD_W-1:0] word_a,
  input  logic [WORD_W-1:0] word_b,
  input  logic [WORD_W-1:0] word_c,
  input  logic              final_a,
  input  logic              final_b,
  input  logic              final_c,
  input  logic [WORD_W-1:0] vertex_count,
  input  logic              swap_en,
  output logic [ELEM_W-1:0] element
);

  logic              rel;
  logic [WORD_W-1:0] enc_a, enc_b, enc_c;
  logic [WORD_W-1:0] val_a, val_b, val_c;

  // Relative encoding only in final-flag mode
  assign rel = (cmd == CMD_TRI_REL);

  assign enc_a = (rel && final_a) ? word_a - vertex_count : word_a + WORD_W'(1);
  assign enc_b = (rel && final_b) ? word_b - vertex_count : word_b + WORD_W'(1);
  assign enc_c = (rel && final_c) ? word_c - vertex_count : word_c + WORD_W'(1);

  // Vertex words pass raw
  assign val_a = (cmd == CMD_VERTEX) ? word_a : enc_a;
  assign val_b = (cmd == CMD_VERTEX) ? word_b : enc_b;
  assign val_c = (cmd == CMD_VERTEX) ? word_c : enc_c;

  assign element = {swap_word(val_c, swap_en), swap_word(val_b, swap_en),
                    swap_word(val_a, swap_en)};

endmodule

>>> hw/rtl/mebp_store.sv
// ----------------------------------------------------------------------------
// mebp_store
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mebp_store
  import mebp_pkg::*;
#(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [ELEM_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [ELEM_W-1:0] rd_data
);

  logic [ELEM_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/mesh_element_block_packer.sv
// ----------------------------------------------------------------------------
// mesh_element_block_packer
// Packs vertex and triangle elements into blocks with a type descriptor.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one element (vertex or triangle) or a flush command in
//   in_tuser. Each element beat is written straight into the element store in
//   the cycle it is taken. When the block fills, or on a flush, the block
//   stops taking beats and emits a descriptor beat (kind 0) followed by one
//   beat per stored element (kind 1); out_tlast marks the final beat.
//   An empty flush emits only a zero descriptor with out_tlast set.
//   Element beats can be taken back to back while idle; during emission the
//   store's single read port gives one element a cycle while the receiver
//   keeps up. Results leave through an output register, so a new element
//   beat may be taken while the last result of a block still waits. A
//   stalled receiver holds the output register and freezes emission;
//   nothing is lost. Reset clears the fill count, type bits, vertex count
//   and swap setting; store contents are undefined until written. cfg_we
//   writes swap_bytes; write it only while idle.
// ----------------------------------------------------------------------------
module mesh_element_block_packer
  import mebp_pkg::*;
#(
  parameter int BLOCK_ELEMENTS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  // config
  input  logic         cfg_we,
  input  logic         cfg_wdata,   // swap_bytes
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,    // word_a, word_b, word_c, final_a, final_b, final_c
  input  logic [1:0]   in_tuser,    // command
  // output stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,   // out_a, out_b, out_c
  output logic         out_tuser,   // kind
  output logic         out_tlast    // last
);

  localparam int AW = (BLOCK_ELEMENTS > 1) ? $clog2(BLOCK_ELEMENTS) : 1;
  localparam int CW = $clog2(BLOCK_ELEMENTS + 1);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [TYPE_W-1:0] type_r, type_nxt;
  logic [WORD_W-1:0] vcnt_r, vcnt_nxt;
  logic [AW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              swap_r;

  logic              out_valid_r;
  logic [ELEM_W-1:0] out_data_r;
  logic              out_kind_r;
  logic              out_last_r;

  cmd_t              cmd;
  logic              in_accept;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [ELEM_W-1:0] wr_data;
  logic              rd_en;
  logic [ELEM_W-1:0] rd_data;
  logic              out_free;
  logic              load_desc;
  logic              load_elem;
  logic              elem_last;

  assign cmd       = cmd_t'(in_tuser);
  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign wr_en     = in_accept && (cmd != CMD_FLUSH);
  assign wr_addr   = fill_r[AW-1:0];
  assign elem_last = (CW'(rd_idx_r) + CW'(1)) == fill_r;

  // Element encode
  mebp_encode u_encode (
    .cmd          (cmd),
    .word_a       (in_tdata[31:0]),
    .word_b       (in_tdata[63:32]),
    .word_c       (in_tdata[95:64]),
    .final_a      (in_tdata[96]),
    .final_b      (in_tdata[97]),
    .final_c      (in_tdata[98]),
    .vertex_count (vcnt_r),
    .swap_en      (swap_r),
    .element      (wr_data)
  );

  // Element store; writes only in idle, reads only while emitting
  mebp_store #(
    .DEPTH  (BLOCK_ELEMENTS),
    .ADDR_W (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_nxt),
    .rd_data (rd_data)
  );

  // Control state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      type_r   <= '0;
      vcnt_r   <= '0;
      rd_idx_r <= '0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      type_r   <= type_nxt;
      vcnt_r   <= vcnt_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r <= 1'b0;
    end else if (cfg_we) begin
      swap_r <= cfg_wdata;
    end
  end

  // Next state and emission control
  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    type_nxt   = type_r;
    vcnt_nxt   = vcnt_r;
    rd_idx_nxt = rd_idx_r;
    rd_en      = 1'b0;
    load_desc  = 1'b0;
    load_elem  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (cmd == CMD_FLUSH) begin
            vcnt_nxt  = '0;
            state_nxt = ST_DESC;
          end else begin
            fill_nxt = fill_r + CW'(1);
            if (cmd == CMD_VERTEX) begin
              type_nxt = type_r | (TYPE_W'(1) << wr_addr);
              vcnt_nxt = vcnt_r + WORD_W'(1);
            end
            if (fill_r == CW'(BLOCK_ELEMENTS - 1)) begin
              state_nxt = ST_DESC;
            end
          end
        end
      end
      ST_DESC: begin
        if (out_free) begin
          load_desc = 1'b1;
          if (fill_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_en      = 1'b1;
            rd_idx_nxt = '0;
            state_nxt  = ST_ELEM;
          end
        end
      end
      ST_ELEM: begin
        if (out_free) begin
          load_elem = 1'b1;
          if (elem_last) begin
            fill_nxt  = '0;
            type_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            rd_en      = 1'b1;
            rd_idx_nxt = rd_idx_r + AW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_desc || load_elem) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (load_desc) begin
      out_data_r <= {{(ELEM_W - WORD_W){1'b0}}, swap_word(type_r, swap_r)};
      out_kind_r <= KIND_DESC;
      out_last_r <= (fill_r == '0);
    end else if (load_elem) begin
      out_data_r <= rd_data;
      out_kind_r <= KIND_ELEM;
      out_last_r <= elem_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // Checks
  a_no_write_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !wr_en)
    else $error("store written while emitting");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(BLOCK_ELEMENTS))
    else $error("fill count out of range");

  a_elem_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ELEM) |-> (fill_r != '0))
    else $error("element emission with empty block");

  a_idle_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (fill_r != CW'(BLOCK_ELEMENTS)))
    else $error("full block left in idle");

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for mesh_element_block_packer. Vertex, triangle and
// flush beats go in through the input stream. A built-in block model (or,
// for some table rows, a hand-written result) predicts every descriptor and
// element beat; each beat that comes out is matched against the oldest
// prediction. Hand-picked table beats run first, then randomized phases
// under both byte orders, random gaps on both sides, one long receiver stall.
// ----------------------------------------------------------------------------
module tb;
  import mebp_pkg::*;

  localparam int BLOCK_LEN    = 32;
  localparam int GAP_MAX      = 13;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PAUSE_CYCLES = 8;
  localparam int PHASE_ITEMS  = 90;

  typedef struct packed {
    logic        kind;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic        last;
  } out_beat_t;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [2:0]  fin;
    int          n_typed;
  } dir_row_t;

  // DUT ports
  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic         cfg_wdata = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;   // word_a, word_b, word_c, final_a, final_b, final_c
  logic [1:0]   in_tuser = '0;   // command
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;       // out_a, out_b, out_c
  logic         out_tuser;       // kind
  logic         out_tlast;       // last

  // block model state
  logic [95:0]  elem_store [BLOCK_LEN];
  int           fill;
  logic [31:0]  type_bits;
  logic [31:0]  vtx_count;
  logic         swap_cfg;

  out_beat_t    step_beats[$];
  out_beat_t    beats_due[$];
  out_beat_t    typed_beats[$];
  dir_row_t     dir_rows[$];

  // run bookkeeping
  int n_items, n_checked, n_errs, n_flush, n_full, holds_done;
  int idle_cycles;
  int tx_burst;
  bit hold_req;

  mesh_element_block_packer #(
    .BLOCK_ELEMENTS(BLOCK_LEN)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic out_beat_t beat(input logic kind, input logic [31:0] a,
                                     input logic [31:0] b, input logic [31:0] c,
                                     input logic last);
    out_beat_t r;
    r.kind = kind;
    r.a    = a;
    r.b    = b;
    r.c    = c;
    r.last = last;
    return r;
  endfunction

  function automatic logic [31:0] order_bytes(input logic [31:0] w, input logic rev);
    logic [31:0] r;
    for (int k = 0; k < 4; k++) r[8*k +: 8] = w[8*(3-k) +: 8];
    return rev ? r : w;
  endfunction

  // final flag only counts in relative mode; everything wraps at 32 bits
  function automatic logic [31:0] encode_idx(input logic [31:0] idx, input logic fin,
                                             input logic rel);
    if (rel && fin) return idx - vtx_count;
    return idx + 32'd1;
  endfunction

  // descriptor first, then the stored elements in slot order
  task automatic emit_block_beats();
    step_beats.push_back(beat(KIND_DESC, order_bytes(type_bits, swap_cfg), '0, '0,
                              fill == 0));
    for (int i = 0; i < fill; i++)
      step_beats.push_back(beat(KIND_ELEM, elem_store[i][31:0], elem_store[i][63:32],
                                elem_store[i][95:64], i + 1 == fill));
    type_bits = '0;
    fill      = 0;
  endtask

  // advance the block model by one accepted input beat
  task automatic pack_element(input cmd_t cmd, input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c, input logic [2:0] fin);
    logic [31:0] wa, wb, wc;
    logic        rel;
    step_beats.delete();
    rel = (cmd == CMD_TRI_REL);
    if (cmd == CMD_FLUSH) begin
      emit_block_beats();
      vtx_count = '0;
      n_flush++;
    end else begin
      if (cmd == CMD_VERTEX) begin
        wa = a;
        wb = b;
        wc = c;
        type_bits[fill] = 1'b1;
      end else begin
        wa = encode_idx(a, fin[0], rel);
        wb = encode_idx(b, fin[1], rel);
        wc = encode_idx(c, fin[2], rel);
      end
      elem_store[fill] = {order_bytes(wc, swap_cfg), order_bytes(wb, swap_cfg),
                          order_bytes(wa, swap_cfg)};
      fill++;
      if (fill == BLOCK_LEN) begin
        emit_block_beats();
        n_full++;
      end
      if (cmd == CMD_VERTEX) vtx_count = vtx_count + 32'd1;
    end
  endtask

  // drive one input beat, then book its results once it is taken
  task automatic send_item(input cmd_t cmd, input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] c, input logic [2:0] fin, input int n_typed);
    int gap;
    if (tx_burst > 0) begin
      gap = 0;
      tx_burst--;
    end else begin
      gap = $urandom_range(0, GAP_MAX);
      if ($urandom_range(0, 19) == 0) tx_burst = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {5'b0, fin, c, b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_items++;
    pack_element(cmd, a, b, c, fin);
    if (n_typed > 0) begin
      repeat (n_typed) beats_due.push_back(typed_beats.pop_front());
    end else begin
      foreach (step_beats[i]) beats_due.push_back(step_beats[i]);
    end
  endtask

  function automatic logic [31:0] pick_index();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, vtx_count + 2);
    if (r == 6) return 32'h0;
    if (r == 7) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  task automatic send_random_item();
    int          r;
    cmd_t        cmd;
    logic [31:0] a, b, c;
    r = $urandom_range(0, 99);
    if (r < 5)       cmd = CMD_FLUSH;
    else if (r < 45) cmd = CMD_VERTEX;
    else if (r < 65) cmd = CMD_TRI_ABS;
    else             cmd = CMD_TRI_REL;
    if (cmd == CMD_TRI_ABS || cmd == CMD_TRI_REL) begin
      a = pick_index();
      b = pick_index();
      c = pick_index();
    end else begin
      a = $urandom();
      b = $urandom();
      c = $urandom();
    end
    send_item(cmd, a, b, c, 3'($urandom_range(0, 7)), 0);
  endtask

  // register write, only once the block has gone quiet
  task automatic write_swap(input logic v);
    while (beats_due.size() != 0) @(posedge clk);
    repeat (PAUSE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    swap_cfg = v;
    cfg_we <= 1'b0;
  endtask

  task automatic dir_item(input cmd_t cmd, input logic [31:0] a, input logic [31:0] b,
                          input logic [31:0] c, input logic [2:0] fin);
    dir_row_t row;
    row.cmd     = cmd;
    row.a       = a;
    row.b       = b;
    row.c       = c;
    row.fin     = fin;
    row.n_typed = 0;
    dir_rows.push_back(row);
  endtask

  // hand-written result for the row added last
  task automatic dir_result(input logic kind, input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] c, input logic last);
    dir_row_t row;
    row = dir_rows.pop_back();
    row.n_typed++;
    dir_rows.push_back(row);
    typed_beats.push_back(beat(kind, a, b, c, last));
  endtask

  // output checker: every taken beat against the oldest prediction
  always @(posedge clk) begin
    out_beat_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = beat(out_tuser, out_tdata[31:0], out_tdata[63:32], out_tdata[95:64], out_tlast);
      n_checked++;
      if (beats_due.size() == 0) begin
        if (n_errs < 10)
          $display("ERROR: unexpected beat kind=%0b a=%h b=%h c=%h last=%0b",
                   got.kind, got.a, got.b, got.c, got.last);
        n_errs++;
      end else begin
        want = beats_due.pop_front();
        if (got.kind !== want.kind || got.a !== want.a || got.b !== want.b ||
            got.c !== want.c || got.last !== want.last) begin
          if (n_errs < 10)
            $display({"ERROR: beat %0d exp kind=%0b a=%h b=%h c=%h last=%0b,",
                      " got kind=%0b a=%h b=%h c=%h last=%0b"},
                     n_checked, want.kind, want.a, want.b, want.c, want.last,
                     got.kind, got.a, got.b, got.c, got.last);
          n_errs++;
        end
      end
    end
  end

  // watchdog on cycles without any beat moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("ERROR: no beat moved for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // receiver: random ready gaps, bursts with none, one long hold
  initial begin
    int gap, burst;
    burst = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end
      if (burst > 0) begin
        gap = 0;
        burst--;
      end else begin
        gap = $urandom_range(0, GAP_MAX);
        if ($urandom_range(0, 19) == 0) burst = $urandom_range(10, 40);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
    end
  end

  // stimulus
  initial begin
    logic swap_seq [5];
    fill      = 0;
    type_bits = '0;
    vtx_count = '0;
    swap_cfg  = 1'b0;
    tx_burst  = 0;
    hold_req  = 1'b0;
    swap_seq  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    // hand-picked beats: empty flush, all-ones and all-zeros words,
    // ignored final flags in absolute mode, relative indices around zero
    dir_item(CMD_FLUSH, 32'h0, 32'h0, 32'h0, 3'b000);
    dir_result(KIND_DESC, 32'h0, 32'h0, 32'h0, 1'b1);
    dir_item(CMD_VERTEX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'b111);
    dir_item(CMD_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'b111);
    dir_result(KIND_DESC, 32'h1, 32'h0, 32'h0, 1'b0);
    dir_result(KIND_ELEM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    dir_item(CMD_TRI_ABS, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 3'b111);
    dir_item(CMD_FLUSH, 32'h0, 32'h0, 32'h0, 3'b000);
    dir_result(KIND_DESC, 32'h0, 32'h0, 32'h0, 1'b0);
    dir_result(KIND_ELEM, 32'h0, 32'h1, 32'h8000_0000, 1'b1);
    dir_item(CMD_VERTEX, 32'h0, 32'h0, 32'h0, 3'b000);
    dir_item(CMD_VERTEX, 32'h3F80_0000, 32'hBF80_0000, 32'h8000_0000, 3'b010);
    dir_item(CMD_TRI_REL, 32'h0, 32'h5, 32'h1, 3'b101);
    dir_item(CMD_TRI_REL, 32'h1, 32'h0, 32'hFFFF_FFFF, 3'b010);
    dir_item(CMD_TRI_REL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'b111);
    dir_item(CMD_TRI_ABS, 32'h0, 32'h1, 32'h2, 3'b000);
    dir_item(CMD_FLUSH, 32'h0, 32'h0, 32'h0, 3'b000);
    // vertex count was cleared by the flush
    dir_item(CMD_TRI_REL, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 3'b111);
    dir_item(CMD_VERTEX, 32'hAAAA_AAAA, 32'h5555_5555, 32'hA5A5_A5A5, 3'b101);
    dir_item(CMD_TRI_REL, 32'h0, 32'h0, 32'h0, 3'b111);
    dir_item(CMD_FLUSH, 32'h0, 32'h0, 32'h0, 3'b000);
    dir_item(CMD_FLUSH, 32'h0, 32'h0, 32'h0, 3'b000);
    dir_result(KIND_DESC, 32'h0, 32'h0, 32'h0, 1'b1);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    write_swap(1'b0);

    foreach (dir_rows[i])
      send_item(dir_rows[i].cmd, dir_rows[i].a, dir_rows[i].b, dir_rows[i].c,
                dir_rows[i].fin, dir_rows[i].n_typed);
    in_tvalid <= 1'b0;

    // random phases; partial blocks carry over across swap changes
    for (int p = 0; p < 5; p++) begin
      write_swap(swap_seq[p]);
      if (p == 1) begin
        hold_req = 1'b1;
        tx_burst = 70;
      end
      repeat (PHASE_ITEMS) send_random_item();
      if (p == 4) send_item(CMD_FLUSH, $urandom(), $urandom(), $urandom(), 3'b000, 0);
      in_tvalid <= 1'b0;
    end

    while (beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (beats_due.size() != 0) n_errs++;

    $display("Run: %0d input beats (%0d flushes, %0d full blocks), %0d output beats checked",
             n_items, n_flush, n_full, n_checked);
    $display("Both byte orders used, %0d long receiver hold(s), %0d mismatches",
             holds_done, n_errs);
    if (n_errs == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
